@@ design/l3h_pkg.sv @@
// Shared types, constants and helpers for the lookup3 byte stream hash.
package l3h_pkg;

  localparam logic [31:0] HASH_INIT  = 32'hdeadbeef;
  localparam logic [31:0] SEED_RESET = 32'hfab99bae;

  localparam int ADDR_W = 2;
  localparam logic [ADDR_W-1:0] ADDR_SEED = '0;

  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int OUT_DEPTH_DEF   = 4;

  localparam int BLOCK_BYTES = 12;
  localparam int BLK_W       = 8 * BLOCK_BYTES;
  localparam int POS_W       = 4;

  // one classified byte from the front end
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        last;
    logic        start;
    logic        empty;
    logic [31:0] init;
  } item_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
  } lanes_t;

  // handoff into the final mix pipeline
  typedef struct packed {
    lanes_t lanes;
    logic   bypass;
  } fin_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int k);
    rotl = (x << k) | (x >> (32 - k));
  endfunction

endpackage

@@ design/l3h_fifo.sv @@
// Small register-based FIFO with one read port.
module l3h_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

@@ design/l3h_front.sv @@
// Front end: accepts bytes, tracks message boundaries, computes start value.
module l3h_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  logic [7:0]     data_byte,
  input  logic [15:0]    message_length,
  input  logic           last,
  input  logic [31:0]    seed,
  input  logic           q_full,
  output logic           q_wr,
  output l3h_pkg::item_t q_item
);
  import l3h_pkg::*;

  logic in_message;
  logic in_message_next;
  logic accept;
  logic len_zero;

  assign accept   = push && !q_full;
  assign len_zero = (message_length == '0);
  assign q_wr     = accept;

  always_comb begin
    q_item.data_byte = data_byte;
    q_item.last      = last;
    q_item.start     = !in_message;
    q_item.empty     = !in_message && len_zero;
    q_item.init      = HASH_INIT + {14'b0, message_length, 2'b00} + seed;
  end

  always_comb begin
    in_message_next = in_message;
    if (accept) begin
      if (!in_message) begin
        in_message_next = !len_zero && !last;
      end else if (last) begin
        in_message_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_message <= 1'b0;
    end else begin
      in_message <= in_message_next;
    end
  end

endmodule

@@ design/l3h_back.sv @@
// Back end: block collection and the iterative six-step block mix.
module l3h_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_empty,
  input  l3h_pkg::item_t q_item,
  output logic           q_rd,
  input  logic           fin_ready,
  output logic           fin_valid,
  output l3h_pkg::fin_t  fin
);
  import l3h_pkg::*;

  localparam int MIX_STEPS = 6;
  localparam int STEP_W    = 3;

  logic [BLK_W-1:0]  blk_data;
  logic [BLK_W-1:0]  blk_data_next;
  logic [POS_W-1:0]  blk_pos;
  logic [POS_W-1:0]  blk_pos_next;
  logic              first_blk;
  logic              first_blk_next;
  logic [31:0]       init_val;
  logic [31:0]       init_val_next;

  logic              mix_busy;
  logic [STEP_W-1:0] mix_step;
  lanes_t            mix_lanes;
  lanes_t            mix_in;
  logic              mix_go;

  logic [POS_W-1:0]  eff_pos;
  logic              eff_first;
  logic [31:0]       eff_init;
  logic [BLK_W-1:0]  wb;
  lanes_t            base;

  function automatic lanes_t add_words(input lanes_t l, input logic [BLK_W-1:0] w);
    lanes_t r;
    r.a = l.a + w[31:0];
    r.b = l.b + w[63:32];
    r.c = l.c + w[95:64];
    return r;
  endfunction

  function automatic lanes_t mix_round(input logic [STEP_W-1:0] s, input lanes_t l);
    lanes_t r;
    r = l;
    unique case (s)
      3'd0: begin r.a = (l.a - l.c) ^ rotl(l.c, 4);  r.c = l.c + l.b; end
      3'd1: begin r.b = (l.b - l.a) ^ rotl(l.a, 6);  r.a = l.a + l.c; end
      3'd2: begin r.c = (l.c - l.b) ^ rotl(l.b, 8);  r.b = l.b + l.a; end
      3'd3: begin r.a = (l.a - l.c) ^ rotl(l.c, 16); r.c = l.c + l.b; end
      3'd4: begin r.b = (l.b - l.a) ^ rotl(l.a, 19); r.a = l.a + l.c; end
      3'd5: begin r.c = (l.c - l.b) ^ rotl(l.b, 4);  r.b = l.b + l.a; end
      default: r = l;
    endcase
    return r;
  endfunction

  // a message start resets the block context for this item
  assign eff_pos   = q_item.start ? '0 : blk_pos;
  assign eff_first = q_item.start || first_blk;
  assign eff_init  = q_item.start ? q_item.init : init_val;

  always_comb begin
    for (int i = 0; i < BLOCK_BYTES; i++) begin
      if (POS_W'(i) == eff_pos) begin
        wb[8*i +: 8] = q_item.data_byte;
      end else if (eff_pos == '0) begin
        wb[8*i +: 8] = '0;
      end else begin
        wb[8*i +: 8] = blk_data[8*i +: 8];
      end
    end
  end

  always_comb begin
    if (eff_first) begin
      base = '{a: eff_init, b: eff_init, c: eff_init};
    end else begin
      base = mix_lanes;
    end
  end

  always_comb begin
    q_rd           = 1'b0;
    fin_valid      = 1'b0;
    fin.lanes      = add_words(base, wb);
    fin.bypass     = 1'b0;
    mix_go         = 1'b0;
    mix_in         = add_words(first_blk ? lanes_t'{a: init_val, b: init_val, c: init_val}
                                         : mix_lanes, blk_data);
    blk_data_next  = blk_data;
    blk_pos_next   = blk_pos;
    first_blk_next = first_blk;
    init_val_next  = init_val;
    if (!q_empty) begin
      if (q_item.empty) begin
        if (fin_ready) begin
          q_rd       = 1'b1;
          fin_valid  = 1'b1;
          fin.lanes  = '{a: q_item.init, b: q_item.init, c: q_item.init};
          fin.bypass = 1'b1;
        end
      end else if (!q_item.start && blk_pos == POS_W'(BLOCK_BYTES)) begin
        // full block plus another byte: hand the block to the mix unit
        if (!mix_busy) begin
          mix_go         = 1'b1;
          first_blk_next = 1'b0;
          if (!q_item.last) begin
            q_rd          = 1'b1;
            blk_data_next = BLK_W'(q_item.data_byte);
            blk_pos_next  = POS_W'(1);
          end else begin
            // last byte waits for the mix, then takes the final path
            blk_data_next = '0;
            blk_pos_next  = '0;
          end
        end
      end else if (!q_item.last) begin
        q_rd           = 1'b1;
        blk_data_next  = wb;
        blk_pos_next   = eff_pos + 1'b1;
        first_blk_next = eff_first;
        init_val_next  = eff_init;
      end else if (fin_ready && (eff_first || !mix_busy)) begin
        q_rd           = 1'b1;
        fin_valid      = 1'b1;
        blk_pos_next   = '0;
        first_blk_next = 1'b1;
        init_val_next  = eff_init;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      blk_pos   <= '0;
      first_blk <= 1'b1;
      mix_busy  <= 1'b0;
      mix_step  <= '0;
    end else begin
      blk_pos   <= blk_pos_next;
      first_blk <= first_blk_next;
      if (mix_go) begin
        mix_busy <= 1'b1;
        mix_step <= '0;
      end else if (mix_busy) begin
        if (mix_step == STEP_W'(MIX_STEPS - 1)) begin
          mix_busy <= 1'b0;
        end else begin
          mix_step <= mix_step + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    blk_data <= blk_data_next;
    init_val <= init_val_next;
    if (mix_go) begin
      mix_lanes <= mix_in;
    end else if (mix_busy) begin
      mix_lanes <= mix_round(mix_step, mix_lanes);
    end
  end

endmodule

@@ design/l3h_final.sv @@
// Seven-stage final mix pipeline; stalls as a whole on a full result queue.
module l3h_final (
  input  logic          clk,
  input  logic          rst,
  input  logic          fin_valid,
  input  l3h_pkg::fin_t fin,
  output logic          fin_ready,
  input  logic          out_full,
  output logic          out_push,
  output logic [31:0]   out_hash
);
  import l3h_pkg::*;

  localparam int STAGES = 7;

  logic [STAGES:0] v;
  fin_t            st [STAGES+1];
  logic            adv;

  function automatic fin_t fin_round(input int k, input fin_t s);
    fin_t r;
    r = s;
    if (!s.bypass) begin
      unique case (k)
        0: r.lanes.c = (s.lanes.c ^ s.lanes.b) - rotl(s.lanes.b, 14);
        1: r.lanes.a = (s.lanes.a ^ s.lanes.c) - rotl(s.lanes.c, 11);
        2: r.lanes.b = (s.lanes.b ^ s.lanes.a) - rotl(s.lanes.a, 25);
        3: r.lanes.c = (s.lanes.c ^ s.lanes.b) - rotl(s.lanes.b, 16);
        4: r.lanes.a = (s.lanes.a ^ s.lanes.c) - rotl(s.lanes.c, 4);
        5: r.lanes.b = (s.lanes.b ^ s.lanes.a) - rotl(s.lanes.a, 14);
        6: r.lanes.c = (s.lanes.c ^ s.lanes.b) - rotl(s.lanes.b, 24);
        default: r = s;
      endcase
    end
    return r;
  endfunction

  assign adv       = !v[STAGES] || !out_full;
  assign fin_ready = adv;
  assign out_push  = v[STAGES] && !out_full;
  assign out_hash  = st[STAGES].lanes.c;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[STAGES-1:0], fin_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st[0] <= fin;
      for (int k = 0; k < STAGES; k++) begin
        st[k+1] <= fin_round(k, st[k]);
      end
    end
  end

endmodule

@@ design/lookup3_byte_stream_hash.sv @@
// Top level of the lookup3 byte stream hash: config register and datapath wiring.
//
//  channel   | direction | handshake           | payload
//  ----------+-----------+---------------------+-------------------------------------
//  bytes     | in        | push / full         | data_byte, message_length, last
//  hashes    | out       | pop / empty         | hash_value
//  config    | in/out    | psel/penable/pready | paddr, pwdata, prdata (seed at 0x0)
//
// One byte per cycle is taken inside a message while the byte queue is not full. The six-step
// block mix runs in an iterative unit while the next block is collected; a last byte that
// lands right after a full block waits for that mix to finish.
// After its last byte is accepted, a result passes through the byte queue, lane adder,
// 8-register final mix pipeline and result queue. Reset is synchronous and sets
// the seed to 0xfab99bae. With pop low the result queue and pipeline fill up,
// then full rises once the byte queue holds QUEUE_DEPTH transactions.
module lookup3_byte_stream_hash #(
  parameter int QUEUE_DEPTH = l3h_pkg::QUEUE_DEPTH_DEF,
  parameter int OUT_DEPTH   = l3h_pkg::OUT_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  output logic                       full,
  input  logic [7:0]                 data_byte,
  input  logic [15:0]                message_length,
  input  logic                       last,
  output logic                       empty,
  input  logic                       pop,
  output logic [31:0]                hash_value,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [l3h_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import l3h_pkg::*;

  logic [31:0] seed;
  logic        q_wr;
  item_t       q_wr_item;
  logic        q_full;
  logic        q_rd;
  item_t       q_item;
  logic        q_empty;
  logic        fin_valid;
  fin_t        fin;
  logic        fin_ready;
  logic        out_push;
  logic [31:0] out_hash;
  logic        out_full;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_SEED) ? seed : '0;
  assign full   = q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= SEED_RESET;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_SEED) begin
      seed <= pwdata;
    end
  end

  l3h_front u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .data_byte      (data_byte),
    .message_length (message_length),
    .last           (last),
    .seed           (seed),
    .q_full         (q_full),
    .q_wr           (q_wr),
    .q_item         (q_wr_item)
  );

  l3h_fifo #(
    .WIDTH ($bits(item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_byte_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_wr),
    .wr_data (q_wr_item),
    .full    (q_full),
    .rd_en   (q_rd),
    .rd_data (q_item),
    .empty   (q_empty)
  );

  l3h_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_item    (q_item),
    .q_rd      (q_rd),
    .fin_ready (fin_ready),
    .fin_valid (fin_valid),
    .fin       (fin)
  );

  l3h_final u_final (
    .clk       (clk),
    .rst       (rst),
    .fin_valid (fin_valid),
    .fin       (fin),
    .fin_ready (fin_ready),
    .out_full  (out_full),
    .out_push  (out_push),
    .out_hash  (out_hash)
  );

  l3h_fifo #(
    .WIDTH (32),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (out_push),
    .wr_data (out_hash),
    .full    (out_full),
    .rd_en   (pop),
    .rd_data (hash_value),
    .empty   (empty)
  );

endmodule

@@ design/l3h_checker.sv @@
// Port-level checks for the lookup3 byte stream hash, bound to the top level.
module l3h_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       full,
  input logic                       empty,
  input logic                       pop,
  input logic [31:0]                hash_value,
  input logic                       psel,
  input logic                       penable,
  input logic                       pwrite,
  input logic                       pready,
  input logic [l3h_pkg::ADDR_W-1:0] paddr,
  input logic [31:0]                pwdata,
  input logic [31:0]                prdata
);
  import l3h_pkg::*;

  a_reset_queues: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("queues not clear after reset");

  a_reset_seed: assert property (@(posedge clk)
    rst |=> (paddr != ADDR_SEED || prdata == SEED_RESET))
    else $error("seed readback wrong after reset");

  a_seed_write: assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite && pready && paddr == ADDR_SEED)
      |=> (paddr != ADDR_SEED || prdata == $past(pwdata)))
    else $error("seed readback does not match written value");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(hash_value)))
    else $error("waiting result changed or vanished");

endmodule

bind lookup3_byte_stream_hash l3h_checker u_l3h_checker (.*);

@@ tb/testbench.sv @@
// Self-checking testbench for the lookup3 byte stream hash.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Tracks lanes and seed per accepted byte; holds the hashes owed by the DUT.
  class lookup3_tracker;
    bit [31:0] seed;
    bit [31:0] lane_a, lane_b, lane_c;
    int unsigned fill;
    bit collecting;
    bit [31:0] hash_due_q[$];
    int errors;

    function new();
      seed = l3h_pkg::SEED_RESET;
      fill = 0;
      collecting = 0;
      errors = 0;
    endfunction

    function bit [31:0] rol(bit [31:0] x, int unsigned k);
      bit [63:0] d;
      d = {x, x} << k;
      return d[63:32];
    endfunction

    function void block_mix();
      lane_a -= lane_c; lane_a ^= rol(lane_c, 4);  lane_c += lane_b;
      lane_b -= lane_a; lane_b ^= rol(lane_a, 6);  lane_a += lane_c;
      lane_c -= lane_b; lane_c ^= rol(lane_b, 8);  lane_b += lane_a;
      lane_a -= lane_c; lane_a ^= rol(lane_c, 16); lane_c += lane_b;
      lane_b -= lane_a; lane_b ^= rol(lane_a, 19); lane_a += lane_c;
      lane_c -= lane_b; lane_c ^= rol(lane_b, 4);  lane_b += lane_a;
    endfunction

    function void final_mix();
      lane_c ^= lane_b; lane_c -= rol(lane_b, 14);
      lane_a ^= lane_c; lane_a -= rol(lane_c, 11);
      lane_b ^= lane_a; lane_b -= rol(lane_a, 25);
      lane_c ^= lane_b; lane_c -= rol(lane_b, 16);
      lane_a ^= lane_c; lane_a -= rol(lane_c, 4);
      lane_b ^= lane_a; lane_b -= rol(lane_a, 14);
      lane_c ^= lane_b; lane_c -= rol(lane_b, 24);
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
    endfunction

    function void absorb_byte(logic [7:0] b, logic [15:0] len, logic is_last);
      bit [31:0] init;
      bit [31:0] addend;
      if (!collecting) begin
        init = l3h_pkg::HASH_INIT + (32'(len) << 2) + seed;
        lane_a = init;
        lane_b = init;
        lane_c = init;
        fill = 0;
        // zero length: initial c comes back at once, byte and last ignored
        if (len == 16'd0) begin
          hash_due_q.push_back(lane_c);
          return;
        end
        collecting = 1;
      end
      // a full block is mixed only once another byte shows up
      if (fill >= 12) begin
        block_mix();
        fill = 0;
      end
      addend = 32'(b) << ((fill % 4) * 8);
      if (fill < 4) lane_a += addend;
      else if (fill < 8) lane_b += addend;
      else lane_c += addend;
      fill++;
      if (is_last) begin
        final_mix();
        collecting = 0;
        fill = 0;
        hash_due_q.push_back(lane_c);
      end
    endfunction

    function void compare_hash(logic [31:0] got);
      bit [31:0] want;
      if (hash_due_q.size() == 0) begin
        flag($sformatf("hash %08h with none expected", got));
        return;
      end
      want = hash_due_q.pop_front();
      if (got !== want) flag($sformatf("hash expected %08h actual %08h", want, got));
    endfunction

    function int pending();
      return hash_due_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic push, full, empty, pop;
  logic [7:0] data_byte;
  logic [15:0] message_length;
  logic last;
  logic [31:0] hash_value;
  logic psel, penable, pwrite, pready;
  logic [l3h_pkg::ADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;

  lookup3_tracker sb = new();
  int items_sent = 0;

  lookup3_byte_stream_hash DUT (
    .clk(clk), .rst(rst),
    .push(push), .full(full),
    .data_byte(data_byte), .message_length(message_length), .last(last),
    .empty(empty), .pop(pop), .hash_value(hash_value),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (push && !full) sb.absorb_byte(data_byte, message_length, last);
      if (pop && !empty) sb.compare_hash(hash_value);
    end
  end

  // result side: short and long stalls, plus stretches with pop held high
  initial begin
    int stall, stream, r;
    stall = 0;
    stream = 0;
    pop = 1'b0;
    forever begin
      @(negedge clk);
      if (rst) begin
        pop <= 1'b0;
      end else if (stream > 0) begin
        stream--;
        pop <= 1'b1;
      end else if (stall > 0) begin
        stall--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
        r = $urandom_range(0, 99);
        if (r < 3) stream = $urandom_range(50, 200);
        else if (r < 20) stall = $urandom_range(1, 3);
        else if (r < 23) stall = $urandom_range(10, 60);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_item(input logic [7:0] b, input logic [15:0] len, input logic fin,
                           input int gap);
    repeat (gap) begin
      @(negedge clk);
      push <= 1'b0;
    end
    @(negedge clk);
    push <= 1'b1;
    data_byte <= b;
    message_length <= len;
    last <= fin;
    do @(posedge clk); while (full);
    items_sent++;
  endtask

  // drop push and wait for every owed hash
  task automatic drain();
    @(negedge clk);
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic settle();
    drain();
    repeat (30) @(posedge clk);
  endtask

  task automatic seed_write(input logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= l3h_pkg::ADDR_SEED;
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.seed = value;
  endtask

  task automatic seed_readback();
    logic [31:0] got;
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= l3h_pkg::ADDR_SEED;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (got !== sb.seed) sb.flag($sformatf("seed expected %08h actual %08h", sb.seed, got));
  endtask

  task automatic send_message();
    int r, count;
    logic [15:0] len_field;
    bit burst;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      send_item(8'($urandom), 16'd0, 1'($urandom), pick_gap());
      return;
    end
    count = (r < 12) ? $urandom_range(30, 200) : $urandom_range(1, 26);
    len_field = 16'(count);
    // broken message: header length can disagree with bytes actually sent
    if ($urandom_range(0, 9) == 0) len_field = 16'($urandom_range(1, 65535));
    burst = ($urandom_range(0, 7) == 0);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 299) == 0) drain();
      send_item(8'($urandom), (i == 0) ? len_field : 16'($urandom), i == count - 1,
                burst ? 0 : pick_gap());
    end
  endtask

  initial begin
    int target;
    bit [31:0] next_seed;
    rst = 1'b1;
    push = 1'b0;
    data_byte = '0;
    message_length = '0;
    last = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    seed_readback();

    // empty messages, with last both low and high
    send_item(8'hff, 16'd0, 1'b0, 0);
    send_item(8'h00, 16'd0, 1'b1, 0);
    // single-byte messages, one with a length far beyond what arrives
    send_item(8'hff, 16'd1, 1'b1, 0);
    send_item(8'h00, 16'hffff, 1'b1, 0);
    // one full block, then last lands right behind it
    for (int i = 0; i < 13; i++)
      send_item((i % 3 == 0) ? 8'hff : 8'(i * 37), (i == 0) ? 16'd13 : 16'($urandom),
                i == 12, 0);
    // more bytes than the header claims
    for (int i = 0; i < 5; i++)
      send_item(8'(8'ha5 ^ i), (i == 0) ? 16'd2 : 16'hffff, i == 4, 0);
    settle();

    for (int k = 0; k < 5; k++) begin
      next_seed = (k == 0) ? 32'h0 : (k == 1) ? 32'hffffffff : 32'($urandom);
      seed_write(next_seed);
      seed_readback();
      target = items_sent + 400;
      while (items_sent < target) send_message();
      settle();
    end

    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule
